// ===== hdl/zctd_pkg.sv =====
// Package for the packed text decoder: codes, types and the per-code decode step.
`default_nettype none
package zctd_pkg;

	localparam logic [1:0] KIND_CHAR = 2'd0;
	localparam logic [1:0] KIND_ABBR = 2'd1;
	localparam logic [1:0] KIND_END  = 2'd2;

	localparam logic [2:0] MODE_A0   = 3'd0;
	localparam logic [2:0] MODE_A1   = 3'd1;
	localparam logic [2:0] MODE_A2   = 3'd2;
	localparam logic [2:0] MODE_ESC1 = 3'd3;
	localparam logic [2:0] MODE_ESC2 = 3'd4;
	localparam logic [2:0] MODE_ABBR = 3'd5;

	localparam logic [6:0] CHR_NEWLINE = 7'd10;
	localparam logic [6:0] CHR_SPACE   = 7'd32;
	localparam logic [6:0] CHR_LOWER_A = 7'd97;
	localparam logic [6:0] CHR_UPPER_A = 7'd65;
	localparam logic [6:0] CHR_DIGIT_0 = 7'd48;

	localparam logic [4:0] CODE_SPACE   = 5'd0;
	localparam logic [4:0] CODE_LASTABB = 5'd3;
	localparam logic [4:0] CODE_ESCAPE  = 5'd6;
	localparam logic [4:0] CODE_NEWLINE = 5'd7;

	typedef struct packed {
		logic [2:0] mode;
		logic [1:0] locked;
		logic [1:0] esc;
		logic [1:0] bank;
	} dec_state_t;

	typedef struct packed {
		dec_state_t st;
		logic       v;
		logic [1:0] kind;
		logic [6:0] value;
	} step_t;

	// one queued word: codes[0] is handled first
	typedef struct packed {
		logic [2:0][4:0] codes;
		logic            endm;
	} qent_t;

	localparam dec_state_t STATE_RESET = '{mode: MODE_A0, locked: 2'd0, esc: 2'd0, bank: 2'd0};

	function automatic logic [6:0] alpha_char(logic [1:0] alph, logic [4:0] code);
		logic [4:0] o;
		logic [6:0] r;
		o = code - CODE_ESCAPE;
		r = CHR_SPACE;
		unique case (alph)
			2'd0: r = CHR_LOWER_A + {2'b00, o};
			2'd1: r = CHR_UPPER_A + {2'b00, o};
			default: begin
				if (o >= 5'd2 && o <= 5'd11) begin
					r = CHR_DIGIT_0 + {2'b00, o - 5'd2};
				end else begin
					case (o)
						5'd12: r = 7'd46;  // .
						5'd13: r = 7'd44;  // ,
						5'd14: r = 7'd33;  // !
						5'd15: r = 7'd63;  // ?
						5'd16: r = 7'd95;  // _
						5'd17: r = 7'd35;  // #
						5'd18: r = 7'd39;  // '
						5'd19: r = 7'd34;  // "
						5'd20: r = 7'd47;  // /
						5'd21: r = 7'd92;  // backslash
						5'd22: r = 7'd45;  // -
						5'd23: r = 7'd58;  // :
						5'd24: r = 7'd40;  // (
						5'd25: r = 7'd41;  // )
						default: r = CHR_SPACE;
					endcase
				end
			end
		endcase
		return r;
	endfunction

	function automatic step_t dec_step(dec_state_t s, logic [4:0] c);
		step_t      r;
		logic [2:0] m;
		logic [1:0] sh;
		r.st    = s;
		r.v     = 1'b0;
		r.kind  = KIND_CHAR;
		r.value = '0;
		m  = (s.mode > MODE_ABBR) ? MODE_A0 : s.mode;
		sh = c[1:0] + 2'd1;  // shift code 4 -> alphabet 1, 5 -> alphabet 2
		if (m == MODE_ABBR) begin
			r.v       = 1'b1;
			r.kind    = KIND_ABBR;
			r.value   = {s.bank, c};
			r.st.mode = {1'b0, s.locked};
		end else if (m == MODE_ESC1) begin
			r.st.esc  = c[1:0];
			r.st.mode = MODE_ESC2;
		end else if (m == MODE_ESC2) begin
			r.v       = 1'b1;
			r.value   = {s.esc, c};
			r.st.mode = {1'b0, s.locked};
		end else if (c >= CODE_ESCAPE) begin
			if (m == MODE_A2 && c == CODE_ESCAPE) begin
				r.st.mode = MODE_ESC1;
			end else begin
				r.v       = 1'b1;
				r.value   = (m == MODE_A2 && c == CODE_NEWLINE) ? CHR_NEWLINE
				            : alpha_char(m[1:0], c);
				r.st.mode = {1'b0, s.locked};
			end
		end else if (c == CODE_SPACE) begin
			r.v       = 1'b1;
			r.value   = CHR_SPACE;
			r.st.mode = {1'b0, s.locked};
		end else if (c <= CODE_LASTABB) begin
			r.st.bank = c[1:0] - 2'd1;
			r.st.mode = MODE_ABBR;
		end else if (m == MODE_A0) begin
			r.st.mode = {1'b0, sh};
		end else if (m[1:0] == sh) begin
			r.st.mode   = m;
			r.st.locked = m[1:0];
		end else begin
			r.st.mode   = MODE_A0;
			r.st.locked = 2'd0;
		end
		return r;
	endfunction

endpackage
`default_nettype wire

// ===== hdl/zctd_if.sv =====
// Handshake interfaces for packed words in and decoded results out.
`default_nettype none
interface zctd_word_if;
	logic        valid;
	logic        ready;
	logic [15:0] packed_word;
	modport source (output valid, output packed_word, input ready);
	modport sink (input valid, input packed_word, output ready);
endinterface

interface zctd_res_if;
	logic       valid;
	logic       ready;
	logic [1:0] kind;
	logic [6:0] value;
	logic       run_last;
	modport source (output valid, output kind, output value, output run_last, input ready);
	modport sink (input valid, input kind, input value, input run_last, output ready);
endinterface
`default_nettype wire

// ===== hdl/zctd_front.sv =====
// Front end: takes packed words, splits them into codes and queues them (two entries).
`default_nettype none
module zctd_front (
	input  wire logic          clk,
	input  wire logic          arst_n,
	zctd_word_if.sink          words,
	output      logic          q_valid,
	input  wire logic          q_ready,
	output      zctd_pkg::qent_t q_data
);

	zctd_pkg::qent_t ent_q [2];
	zctd_pkg::qent_t ent_in;
	logic            wp_q;
	logic            rp_q;
	logic [1:0]      cnt_q;
	logic            push;
	logic            pop;

	always_comb begin
		ent_in.codes[0] = words.packed_word[14:10];
		ent_in.codes[1] = words.packed_word[9:5];
		ent_in.codes[2] = words.packed_word[4:0];
		ent_in.endm     = words.packed_word[15];
	end

	assign words.ready = (cnt_q != 2'd2);
	assign push        = words.valid && words.ready;
	assign q_valid     = (cnt_q != 2'd0);
	assign pop         = q_valid && q_ready;
	assign q_data      = ent_q[rp_q];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wp_q  <= 1'b0;
			rp_q  <= 1'b0;
			cnt_q <= 2'd0;
		end else begin
			if (push) wp_q <= ~wp_q;
			if (pop) rp_q <= ~rp_q;
			cnt_q <= cnt_q + {1'b0, push} - {1'b0, pop};
		end
	end

	always_ff @(posedge clk) begin
		if (push) ent_q[wp_q] <= ent_in;
	end

endmodule
`default_nettype wire

// ===== hdl/zctd_back.sv =====
// Back end: walks queued codes one per cycle unless stalled; registers results.
`default_nettype none
module zctd_back (
	input  wire logic            clk,
	input  wire logic            arst_n,
	input  wire logic            q_valid,
	output      logic            q_ready,
	input  wire zctd_pkg::qent_t q_data,
	zctd_res_if.source           results
);

	zctd_pkg::dec_state_t st_q;
	logic [1:0]           k_q;
	logic                 ov_q;
	logic [1:0]           okind_q;
	logic [6:0]           oval_q;
	logic                 olast_q;

	logic [4:0]      c0;
	logic [4:0]      c1;
	zctd_pkg::step_t r0;
	zctd_pkg::step_t r1;
	zctd_pkg::step_t r2;
	logic            end_step;
	logic            later;
	logic            res_v;
	logic            can_load;
	logic            fire;
	logic            word_done;

	always_comb begin
		unique case (k_q)
			2'd0: begin
				c0 = q_data.codes[0];
				c1 = q_data.codes[1];
			end
			2'd1: begin
				c0 = q_data.codes[1];
				c1 = q_data.codes[2];
			end
			default: begin
				c0 = q_data.codes[2];
				c1 = q_data.codes[2];
			end
		endcase
	end

	// look ahead over the rest of the word to know which result is its last
	assign r0       = zctd_pkg::dec_step(st_q, c0);
	assign r1       = zctd_pkg::dec_step(r0.st, c1);
	assign r2       = zctd_pkg::dec_step(r1.st, q_data.codes[2]);
	assign end_step = (k_q == 2'd3);
	assign later    = ((k_q <= 2'd1) && r1.v) || ((k_q == 2'd0) && r2.v) || q_data.endm;
	assign res_v    = end_step || r0.v;
	assign can_load = !ov_q || results.ready;
	assign fire     = q_valid && (!res_v || can_load);
	assign word_done = end_step || ((k_q == 2'd2) && !q_data.endm);
	assign q_ready  = fire && word_done;

	assign results.valid    = ov_q;
	assign results.kind     = okind_q;
	assign results.value    = oval_q;
	assign results.run_last = olast_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			st_q <= zctd_pkg::STATE_RESET;
			k_q  <= 2'd0;
			ov_q <= 1'b0;
		end else begin
			if (fire) begin
				if (end_step) st_q <= zctd_pkg::STATE_RESET;
				else st_q <= r0.st;
				k_q <= word_done ? 2'd0 : k_q + 2'd1;
			end
			if (fire && res_v) ov_q <= 1'b1;
			else if (results.ready) ov_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (fire && res_v) begin
			if (end_step) begin
				okind_q <= zctd_pkg::KIND_END;
				oval_q  <= '0;
				olast_q <= 1'b1;
			end else begin
				okind_q <= r0.kind;
				oval_q  <= r0.value;
				olast_q <= !later;
			end
		end
	end

endmodule
`default_nettype wire

// ===== hdl/zchar_text_decoder.sv =====
// Top level of the packed text decoder: front queue, code sequencer, checks.
// Results of a word pass through the queue entry register and then the result register to the output.
// The sequencer takes one code per cycle while the result register can take a result; an end mark adds an end step.
// A two-word queue lets words come in while results wait downstream.
// Reset (arst_n low) empties the queue, drops any pending result and returns
// alphabet, lock, escape and abbreviation state to lowercase / zero.
`default_nettype none
module zchar_text_decoder (
	input wire logic   clk,
	input wire logic   arst_n,
	zctd_word_if.sink  words,
	zctd_res_if.source results
);

	logic            q_valid;
	logic            q_ready;
	zctd_pkg::qent_t q_data;

	zctd_front u_front (
		.clk     (clk),
		.arst_n  (arst_n),
		.words   (words),
		.q_valid (q_valid),
		.q_ready (q_ready),
		.q_data  (q_data)
	);

	zctd_back u_back (
		.clk     (clk),
		.arst_n  (arst_n),
		.q_valid (q_valid),
		.q_ready (q_ready),
		.q_data  (q_data),
		.results (results)
	);

	// a full queue always offers a word to the sequencer
	a_full_has_head: assert property (@(posedge clk) disable iff (!arst_n)
		!words.ready |-> q_valid)
		else $error("queue full but no head word");

	a_end_is_last: assert property (@(posedge clk) disable iff (!arst_n)
		(results.valid && results.kind == zctd_pkg::KIND_END) |->
		(results.run_last && results.value == 7'd0))
		else $error("end result malformed");

	a_abbr_range: assert property (@(posedge clk) disable iff (!arst_n)
		(results.valid && results.kind == zctd_pkg::KIND_ABBR) |-> results.value[6:5] != 2'b11)
		else $error("abbreviation index out of range");

	// a word leaves the queue only on a cycle the queue holds one
	a_pop_needs_room: assert property (@(posedge clk) disable iff (!arst_n)
		q_ready |-> q_valid)
		else $error("queue popped while empty");

endmodule
`default_nettype wire
